>>> hw/rtl/wsol_pkg.sv
// Shared types, widths and codes for the window stacking order list.
package wsol_pkg;

    localparam int MAX_WINDOWS = 64;
    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);
    localparam int ID_W = 29;
    localparam int KIND_W = 3;
    localparam int POS_W = 6;
    localparam int STAT_W = 3;
    localparam int DEPTH_W = 7;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RAISE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOWER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STAT_W-1:0] ST_WIN_ABSENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_SIB_ABSENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd5;

    typedef struct packed {
        logic             load;
        logic             up;
        logic             dn;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [ID_W-1:0]  val;
    } t_cell_ctl;

    typedef struct packed {
        logic win;
        logic sib;
    } t_cell_hit;

endpackage

>>> hw/rtl/window_stacking_order_list.sv
// Window stacking order list: top level with sequencer and row of cells.
//
// Input channel: i_in_valid / o_in_stall with i_kind, i_window_id,
// i_sibling_id and i_position; a beat is taken when valid is high and
// stall is low. Output channel: o_out_valid / i_out_stall with o_status,
// o_changed, o_depth and o_entry_window; one result beat per input beat.
// Each item passes the accept step (S_IDLE), a compare step (S_CMP) in
// which every cell compares its id against the window and sibling
// (indices encoded and registered), and an update step (S_EXEC) in which
// the row shifts or loads and the result is written to the output
// register. A new item is taken only once the last has left S_EXEC.
// The output register decouples the sides: a new beat is taken while a
// result still waits. If the receiver stalls, the finished result holds
// and the next item waits in its update step until the register frees.
// Reset clears the depth to zero and empties the output register; no
// clearing pass is needed.
module window_stacking_order_list import wsol_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ID_W-1:0]   i_window_id,
    input  logic [ID_W-1:0]   i_sibling_id,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic              o_changed,
    output logic [DEPTH_W-1:0] o_depth,
    output logic [ID_W-1:0]   o_entry_window
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_kind;
    logic [ID_W-1:0]   r_win, r_sib;
    logic [POS_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_at, r_sp;
    logic              r_at_ok, r_sp_ok;
    logic [ID_W-1:0]   r_rd;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_changed, n_changed;
    logic [ID_W-1:0]   r_entry, n_entry;

    logic [ID_W-1:0]   w_val [MAX_WINDOWS];
    logic [ID_W-1:0]   w_rd [MAX_WINDOWS];
    t_cell_hit         w_hit [MAX_WINDOWS];
    t_cell_ctl         ctl, ctl_go;

    logic              take;
    logic              go;
    logic [IDX_W-1:0]  at_enc, sp_enc;
    logic              at_any, sp_any;
    logic [ID_W-1:0]   rd_or;
    logic [CNT_W-1:0]  from_p1, ap1;

    assign take = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign go = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOWS; g++) begin : g_cell
            logic [ID_W-1:0] up_v, dn_v;
            if (g == MAX_WINDOWS - 1) begin : g_top
                assign up_v = '0;
            end else begin : g_mid
                assign up_v = w_val[g+1];
            end
            if (g == 0) begin : g_bot
                assign dn_v = '0;
            end else begin : g_upr
                assign dn_v = w_val[g-1];
            end
            wsol_cell u_cell (
                .i_clk    (i_clk),
                .i_idx    (IDX_W'(g)),
                .i_count  (r_count),
                .i_win    (r_win),
                .i_sib    (r_sib),
                .i_pos    (r_pos),
                .i_ctl    (ctl_go),
                .i_up_val (up_v),
                .i_dn_val (dn_v),
                .o_val    (w_val[g]),
                .o_hit    (w_hit[g]),
                .o_rd     (w_rd[g])
            );
        end
    endgenerate

    // Live ids are distinct, so each hit vector is one-hot or empty.
    always_comb begin
        at_enc = '0;
        sp_enc = '0;
        at_any = 1'b0;
        sp_any = 1'b0;
        rd_or = '0;
        for (int i = 0; i < MAX_WINDOWS; i++) begin
            at_enc = at_enc | (w_hit[i].win ? IDX_W'(i) : '0);
            sp_enc = sp_enc | (w_hit[i].sib ? IDX_W'(i) : '0);
            at_any = at_any | w_hit[i].win;
            sp_any = sp_any | w_hit[i].sib;
            rd_or = rd_or | w_rd[i];
        end
    end

    // ap1 is the target "above" position plus one.
    assign from_p1 = CNT_W'(r_at) + CNT_W'(1);
    always_comb begin
        if (r_sib == '0) begin
            ap1 = (r_kind == KIND_RAISE) ? '0 : r_count;
        end else begin
            ap1 = (r_kind == KIND_RAISE) ? CNT_W'(r_sp) + CNT_W'(1) : CNT_W'(r_sp);
        end
    end

    always_comb begin
        ctl = '0;
        ctl.val = r_win;
        ctl.hi = IDX_W'(MAX_WINDOWS - 1);
        n_status = ST_OK;
        n_changed = 1'b0;
        n_entry = '0;
        n_count = r_count;
        if (r_kind == KIND_ADD) begin
            priority if (r_win == '0) begin
                n_status = ST_WIN_ABSENT;
            end else if (r_at_ok) begin
                n_status = ST_PRESENT;
            end else if (r_count >= CNT_W'(MAX_WINDOWS)) begin
                n_status = ST_FULL;
            end else begin
                ctl.load = 1'b1;
                ctl.dest = IDX_W'(r_count);
                n_count = r_count + CNT_W'(1);
                n_changed = 1'b1;
            end
        end else if (r_kind == KIND_REMOVE) begin
            if (!r_at_ok) begin
                n_status = ST_WIN_ABSENT;
            end else begin
                ctl.up = 1'b1;
                ctl.lo = r_at;
                n_count = r_count - CNT_W'(1);
                n_changed = 1'b1;
            end
        end else if ((r_kind == KIND_RAISE) || (r_kind == KIND_LOWER)) begin
            priority if (!r_at_ok) begin
                n_status = ST_WIN_ABSENT;
            end else if ((r_sib != '0) && !r_sp_ok) begin
                n_status = ST_SIB_ABSENT;
            end else if (from_p1 < ap1) begin
                ctl.up = 1'b1;
                ctl.load = 1'b1;
                ctl.lo = r_at;
                ctl.hi = IDX_W'(ap1 - CNT_W'(2));
                ctl.dest = IDX_W'(ap1 - CNT_W'(1));
                n_changed = 1'b1;
            end else if (CNT_W'(r_at) > ap1) begin
                ctl.dn = 1'b1;
                ctl.load = 1'b1;
                ctl.dest = IDX_W'(ap1);
                ctl.lo = IDX_W'(ap1 + CNT_W'(1));
                ctl.hi = r_at;
                n_changed = 1'b1;
            end else begin
                n_changed = 1'b0;
            end
        end else if (r_kind == KIND_READ) begin
            if (CMP_W'(r_pos) < CMP_W'(r_count)) begin
                n_entry = r_rd;
            end else begin
                n_status = ST_RANGE;
            end
        end
    end

    always_comb begin
        ctl_go = ctl;
        ctl_go.load = ctl.load && go;
        ctl_go.up = ctl.up && go;
        ctl_go.dn = ctl.dn && go;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take) n_state = S_CMP;
            S_CMP: n_state = S_EXEC;
            S_EXEC: if (go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (go) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (go) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind <= i_kind;
            r_win <= i_window_id;
            r_sib <= i_sibling_id;
            r_pos <= i_position;
        end
        if (r_state == S_CMP) begin
            r_at <= at_enc;
            r_sp <= sp_enc;
            r_at_ok <= at_any;
            r_sp_ok <= sp_any;
            r_rd <= rd_or;
        end
        if (go) begin
            r_status <= n_status;
            r_changed <= n_changed;
            r_entry <= n_entry;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_status;
    assign o_changed = r_changed;
    assign o_depth = DEPTH_W'(r_count);
    assign o_entry_window = r_entry;

endmodule

>>> hw/rtl/wsol_cell.sv
// One slot of the stacking order: holds an id, matches it, shifts with its neighbors.
module wsol_cell import wsol_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [CNT_W-1:0] i_count,
    input  logic [ID_W-1:0]  i_win,
    input  logic [ID_W-1:0]  i_sib,
    input  logic [POS_W-1:0] i_pos,
    input  t_cell_ctl        i_ctl,
    input  logic [ID_W-1:0]  i_up_val,
    input  logic [ID_W-1:0]  i_dn_val,
    output logic [ID_W-1:0]  o_val,
    output t_cell_hit        o_hit,
    output logic [ID_W-1:0]  o_rd
);

    logic [ID_W-1:0] r_val;
    logic [ID_W-1:0] n_val;
    logic            live;
    logic            in_rng;

    assign live = CMP_W'(i_idx) < CMP_W'(i_count);
    assign in_rng = (i_idx >= i_ctl.lo) && (i_idx <= i_ctl.hi);

    assign o_hit.win = live && (r_val == i_win) && (i_win != '0);
    assign o_hit.sib = live && (r_val == i_sib) && (i_sib != '0);
    assign o_rd = (CMP_W'(i_idx) == CMP_W'(i_pos)) ? r_val : '0;
    assign o_val = r_val;

    always_comb begin
        priority if (i_ctl.load && (i_idx == i_ctl.dest)) begin
            n_val = i_ctl.val;
        end else if (i_ctl.up && in_rng) begin
            n_val = i_up_val;
        end else if (i_ctl.dn && in_rng) begin
            n_val = i_dn_val;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> hw/rtl/wsol_chk.sv
// Port-level checks for the window stacking order list, bound to the top level.
module wsol_chk import wsol_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [KIND_W-1:0]  i_kind,
    input logic [ID_W-1:0]    i_window_id,
    input logic [ID_W-1:0]    i_sibling_id,
    input logic [POS_W-1:0]   i_position,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [STAT_W-1:0]  o_status,
    input logic               o_changed,
    input logic [DEPTH_W-1:0] o_depth,
    input logic [ID_W-1:0]    o_entry_window
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before item finished");

    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_depth) <= 32'(MAX_WINDOWS)))
        else $error("depth above capacity");

    a_changed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_changed |-> (o_status == ST_OK))
        else $error("order changed with error status");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_entry_window != '0) |-> (o_status == ST_OK) && !o_changed)
        else $error("entry reported on non-read result");

endmodule

bind window_stacking_order_list wsol_chk u_wsol_chk (.*);
